/* rtl/core/bascs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bascs_pkg
// Types and constants for the byte-aligned start code search block.
// ----------------------------------------------------------------------------
package bascs_pkg;

  // byte counter width, counter wraps at this width
  localparam int unsigned POS_W = 32;

  // output position field width
  localparam int unsigned OUT_POS_W = 32;

  // result queue depth and pointer width
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // start code values
  localparam logic [31:0] SC_LIMIT = 32'h0000_01ff;
  localparam logic [31:0] SC_GROUP = 32'h0000_01b3;
  localparam logic [31:0] SC_VOP   = 32'h0000_01b6;
  localparam logic [31:0] SC_SEQ   = 32'h0000_01b0;
  localparam logic [31:0] SC_EOS   = 32'h0000_01b1;
  localparam logic [31:0] SC_USER  = 32'h0000_01b2;

  // configuration register indexes
  localparam logic [1:0] CFG_FCODE             = 2'd0;
  localparam logic [1:0] CFG_SKIP_VIDEO_PACKET = 2'd1;
  localparam logic [1:0] CFG_DETECT_USER_DATA  = 2'd2;

  // result kinds
  typedef enum logic [2:0] {
    KIND_GROUP        = 3'd0,
    KIND_VOP          = 3'd1,
    KIND_SEQUENCE     = 3'd2,
    KIND_END_OF_SEQ   = 3'd3,
    KIND_USER_DATA    = 3'd4,
    KIND_VIDEO_PACKET = 3'd5,
    KIND_NO_MORE_DATA = 3'd6
  } code_kind_t;

  // one queued result
  typedef struct packed {
    code_kind_t           kind;
    logic [OUT_POS_W-1:0] position;
    logic                 final_result;
  } result_t;

endpackage : bascs_pkg
`default_nettype wire

/* rtl/core/byte_aligned_start_code_search_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// byte_aligned_start_code_search_top
// Byte-aligned start code search over a stream of bitstream bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle on the in_ channel while in_tready
// is high and checks the 32-bit window ending at each byte once four bytes of
// the current stream are held. Group of VOP, VOP, visual object sequence, end
// of sequence and, when enabled, user data start codes are reported, as are
// video packet resync markers when fcode is nonzero and skip_video_packet is
// 0. A match reports the byte offset where its window starts. The byte flagged
// by in_tlast also gives a no-more-data result (out_tlast high) carrying the byte
// count, and then the window and counter return to zero for the next stream.
// Each byte is classified in its accept cycle and its results are written to
// a four-entry result queue; the queue drains one result per cycle while
// out_tready is high. With out_tready high a byte is taken every cycle; a
// match on the final byte gives two results. in_tready is high while the queue
// has room for two results. Configuration writes on the cfg_ port take effect
// at the next edge and should only be made while idle.
// ----------------------------------------------------------------------------
module byte_aligned_start_code_search_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_wdata,
  // byte stream in
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_data
  // results out
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [2:0] code_kind, [34:3] code_position
  output      logic        out_tlast   // final_result
);

  // configuration registers
  logic [2:0] fcode_r;
  logic       skip_vp_r;
  logic       detect_ud_r;

  // stream state
  logic [23:0]                   window_r, window_nxt;
  logic [bascs_pkg::POS_W-1:0]   seen_r, seen_nxt;
  logic [1:0]                    fill_r, fill_nxt;

  // result queue
  bascs_pkg::result_t              queue_r [bascs_pkg::QUEUE_DEPTH];
  logic [bascs_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [bascs_pkg::QCNT_W-1:0]    count_r, count_nxt;

  // classification
  logic                          in_req;
  logic                          out_req;
  logic [31:0]                   win;
  logic [4:0]                    vp_shift;
  logic                          match;
  bascs_pkg::code_kind_t         match_kind;
  bascs_pkg::result_t            match_res;
  bascs_pkg::result_t            end_res;
  bascs_pkg::result_t            first_res;
  logic [bascs_pkg::POS_W-1:0]   seen_inc;
  logic [1:0]                    n_wr;

  assign in_req  = in_tvalid & in_tready;
  assign out_req = out_tvalid & out_tready;

  // room for the worst case of two results
  assign in_tready  = (count_r <= bascs_pkg::QCNT_W'(bascs_pkg::QUEUE_DEPTH - 2));
  assign out_tvalid = (count_r != '0);

  // window ending at the new byte, oldest byte on top
  assign win      = {window_r, in_tdata};
  assign vp_shift = 5'd16 - {2'b00, fcode_r};

  always_comb begin
    match      = 1'b0;
    match_kind = bascs_pkg::KIND_GROUP;
    if (fill_r == 2'd3) begin
      if (win <= bascs_pkg::SC_LIMIT) begin
        // short window: compare against the start codes
        if (win == bascs_pkg::SC_GROUP) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_GROUP;
        end else if (win == bascs_pkg::SC_VOP) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_VOP;
        end else if (win == bascs_pkg::SC_SEQ) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_SEQUENCE;
        end else if (win == bascs_pkg::SC_EOS) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_END_OF_SEQ;
        end else if (detect_ud_r && (win == bascs_pkg::SC_USER)) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_USER_DATA;
        end
      end else if (!skip_vp_r && (fcode_r != 3'd0)) begin
        // resync marker: top 15+fcode bits are zeros then a one
        if ((win >> vp_shift) == 32'd1) begin
          match      = 1'b1;
          match_kind = bascs_pkg::KIND_VIDEO_PACKET;
        end
      end
    end
  end

  assign seen_inc = seen_r + bascs_pkg::POS_W'(1);

  always_comb begin
    match_res.kind         = match_kind;
    match_res.position     = bascs_pkg::OUT_POS_W'(seen_r - bascs_pkg::POS_W'(3));
    match_res.final_result = 1'b0;
    end_res.kind           = bascs_pkg::KIND_NO_MORE_DATA;
    end_res.position       = bascs_pkg::OUT_POS_W'(seen_inc);
    end_res.final_result   = 1'b1;
    first_res              = match ? match_res : end_res;
    n_wr                   = in_req ? ({1'b0, match} + {1'b0, in_tlast}) : 2'd0;
  end

  // next stream state
  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    fill_nxt   = fill_r;
    if (in_req) begin
      if (in_tlast) begin
        window_nxt = '0;
        seen_nxt   = '0;
        fill_nxt   = '0;
      end else begin
        window_nxt = {window_r[15:0], in_tdata};
        seen_nxt   = seen_inc;
        fill_nxt   = (fill_r == 2'd3) ? fill_r : fill_r + 2'd1;
      end
    end
  end

  assign count_nxt = count_r + bascs_pkg::QCNT_W'(n_wr)
                     - bascs_pkg::QCNT_W'(out_req);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcode_r     <= '0;
      skip_vp_r   <= 1'b0;
      detect_ud_r <= 1'b0;
      window_r    <= '0;
      seen_r      <= '0;
      fill_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bascs_pkg::CFG_FCODE:             fcode_r     <= cfg_wdata;
          bascs_pkg::CFG_SKIP_VIDEO_PACKET: skip_vp_r   <= cfg_wdata[0];
          bascs_pkg::CFG_DETECT_USER_DATA:  detect_ud_r <= cfg_wdata[0];
          default: ; // unlisted index, write dropped
        endcase
      end
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      fill_r   <= fill_nxt;
      wr_ptr_r <= wr_ptr_r + bascs_pkg::QPTR_W'(n_wr);
      if (out_req) begin
        rd_ptr_r <= rd_ptr_r + bascs_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // queue payload, match result first then end result
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      queue_r[wr_ptr_r] <= first_res;
    end
    if (n_wr == 2'd2) begin
      queue_r[wr_ptr_r + bascs_pkg::QPTR_W'(1)] <= end_res;
    end
  end

  assign out_tdata = {5'd0, queue_r[rd_ptr_r].position, queue_r[rd_ptr_r].kind};
  assign out_tlast = queue_r[rd_ptr_r].final_result;

endmodule : byte_aligned_start_code_search_top
`default_nettype wire

/* tb/sv/start_code_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_code_checker
// Watches the configuration port and both streams of the start code search
// block. It keeps its own copy of the window and the byte counter, works out
// the results of each accepted byte, and compares every result that leaves
// the block against the oldest one still owed.
// ----------------------------------------------------------------------------
module start_code_checker
  import bascs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_data
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,  // [2:0] code_kind, [34:3] code_position
  input  wire logic        out_tlast,  // final_result
  output int               fail_count,
  output int               pending_count
);

  // register copies
  logic [2:0]       fcode_q;
  logic             skip_vp_q;
  logic             user_data_q;

  // stream state
  logic [23:0]      window_q;
  logic [POS_W-1:0] byte_count_q;
  logic [1:0]       fill_q;

  result_t          expected_codes[$];

  // no-more-data doubles as "no match" here, a window never yields it
  function automatic code_kind_t classify_window(input logic [31:0] w);
    code_kind_t kind;
    kind = KIND_NO_MORE_DATA;
    if (w <= SC_LIMIT) begin
      case (w)
        SC_GROUP: kind = KIND_GROUP;
        SC_VOP:   kind = KIND_VOP;
        SC_SEQ:   kind = KIND_SEQUENCE;
        SC_EOS:   kind = KIND_END_OF_SEQ;
        SC_USER:  if (user_data_q) kind = KIND_USER_DATA;
        default: ;
      endcase
    end else if (!skip_vp_q && fcode_q != 3'd0 && (w >> (16 - fcode_q)) == 32'd1) begin
      kind = KIND_VIDEO_PACKET;
    end
    return kind;
  endfunction

  task automatic predict_byte(input logic [7:0] data, input logic last);
    code_kind_t kind;
    result_t    r;
    kind = classify_window({window_q, data});
    if (fill_q == 2'd3 && kind != KIND_NO_MORE_DATA) begin
      r.kind         = kind;
      r.position     = byte_count_q - 3;
      r.final_result = 1'b0;
      expected_codes.push_back(r);
    end
    window_q     = {window_q[15:0], data};
    byte_count_q = byte_count_q + 1;
    if (fill_q != 2'd3) fill_q = fill_q + 2'd1;
    if (last) begin
      r.kind         = KIND_NO_MORE_DATA;
      r.position     = byte_count_q;
      r.final_result = 1'b1;
      expected_codes.push_back(r);
      window_q     = '0;
      byte_count_q = '0;
      fill_q       = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      fcode_q      = '0;
      skip_vp_q    = 1'b0;
      user_data_q  = 1'b0;
      window_q     = '0;
      byte_count_q = '0;
      fill_q       = '0;
      fail_count   = 0;
      expected_codes.delete();
    end else begin
      // results leave only after their byte's queue write is registered, so check first
      if (out_tvalid && out_tready) begin
        got.kind         = code_kind_t'(out_tdata[2:0]);
        got.position     = out_tdata[34:3];
        got.final_result = out_tlast;
        if (expected_codes.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: kind %0d position %0d final %0b",
                   $time, got.kind, got.position, got.final_result);
        end else begin
          want = expected_codes.pop_front();
          if (got.kind !== want.kind || got.position !== want.position ||
              got.final_result !== want.final_result) begin
            fail_count++;
            $display("%0t: expected kind %0d position %0d final %0b, got kind %0d position %0d final %0b",
                     $time, want.kind, want.position, want.final_result,
                     got.kind, got.position, got.final_result);
          end
        end
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      // a write lands after this edge's byte was classified
      if (cfg_we) begin
        case (cfg_index)
          CFG_FCODE:             fcode_q     = cfg_wdata;
          CFG_SKIP_VIDEO_PACKET: skip_vp_q   = cfg_wdata[0];
          CFG_DETECT_USER_DATA:  user_data_q = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending_count <= expected_codes.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the byte-aligned start code search block. A short
// directed part hits each start code, a marker and short streams; random
// streams built mostly from start codes and resync markers follow under a
// number of register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import bascs_pkg::*;

  localparam int          PHASE_ITEMS  = 62;       // fewest bytes per random phase
  localparam int          DRAIN_CYCLES = 12;       // queue depth plus margin
  localparam int          LONG_HOLD    = 200;      // receiver hold-off, cycles
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;     // index the block ignores

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [2:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_data
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [2:0] code_kind, [34:3] code_position
  logic        out_tlast;  // final_result

  int          fail_count;
  int          pending_count;

  // control between the sender and the result sink
  bit          hold_req;   // ask the sink for one long hold-off
  bit          no_idle;    // both sides run flat out

  logic [7:0]  stream_bytes[$];

  byte_aligned_start_code_search_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  start_code_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte and hold it until the block takes it, then maybe idle
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (!no_idle && $urandom_range(0, 99) < 35) begin
      gap = pick_gap();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send the queued stream, the last byte flagged as end of data
  task automatic flush_stream();
    for (int i = 0; i < stream_bytes.size(); i++)
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // stop sending until every owed result is out; bytes that give no result
  // may still be in flight, so let the queue settle afterwards too
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers while idle, optionally poke the unused index;
  // the one-bit registers get random upper data bits, only bit 0 counts
  task automatic apply_config(input logic [2:0] fcode, input logic skip_vp,
                              input logic user_data, input bit stray);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FCODE;
    cfg_wdata <= fcode;
    @(posedge clk);
    cfg_index <= CFG_SKIP_VIDEO_PACKET;
    cfg_wdata <= {2'($urandom_range(0, 3)), skip_vp};
    @(posedge clk);
    cfg_index <= CFG_DETECT_USER_DATA;
    cfg_wdata <= {2'($urandom_range(0, 3)), user_data};
    @(posedge clk);
    if (stray) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= 3'($urandom_range(0, 7));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random stream: a few are shorter than a window, the rest are mostly
  // start codes (some broken), resync markers and zero runs
  task automatic build_stream(input logic [2:0] fcode);
    int         len;
    int         r;
    int         sh;
    logic [2:0] mark_f;
    logic [7:0] suffix;
    stream_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 3);
      repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(4, 40);
      while (stream_bytes.size() < len) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          case ($urandom_range(0, 6))
            0:       suffix = SC_SEQ[7:0];
            1:       suffix = SC_EOS[7:0];
            2:       suffix = SC_USER[7:0];
            3:       suffix = SC_GROUP[7:0];
            4:       suffix = SC_VOP[7:0];
            5:       suffix = SC_LIMIT[7:0];
            default: suffix = 8'($urandom_range(0, 255));
          endcase
          stream_bytes.push_back(8'h00);
          stream_bytes.push_back(8'h00);
          stream_bytes.push_back(8'h01);
          stream_bytes.push_back(suffix);
        end else if (r < 50) begin
          // marker for the live f_code mostly, sometimes for another one
          mark_f = (fcode != 3'd0 && $urandom_range(0, 3) != 0) ? fcode
                                                                  : 3'($urandom_range(1, 7));
          sh = 8 - mark_f;
          stream_bytes.push_back(8'h00);
          stream_bytes.push_back(8'h00);
          stream_bytes.push_back(8'((1 << sh) | ($urandom_range(0, 255) & ((1 << sh) - 1))));
          stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (r < 60) begin
          repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'h00);
        end else begin
          stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // one register setting, then random streams; with pressure the sink holds
  // off for a long stretch while bytes keep coming with no gaps
  task automatic random_phase(input logic [2:0] fcode, input logic skip_vp,
                              input logic user_data, input bit stray, input bit pressure);
    int sent;
    apply_config(fcode, skip_vp, user_data, stray);
    if (pressure) begin
      no_idle  = 1'b1;
      hold_req = 1'b1;
    end
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      build_stream(fcode);
      sent += stream_bytes.size();
      flush_stream();
      if (sent > 40) no_idle = 1'b0;
    end
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    hold_req   = 1'b0;
    no_idle    = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FCODE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset values: one-byte stream of all ones
    stream_bytes = '{8'hff};
    flush_stream();
    // group of vop, then vop landing on the final byte
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'hb3, 8'h00, 8'h00, 8'h01, 8'hb6};
    flush_stream();
    // visual object sequence, then end of sequence on the final byte
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'hb0, 8'h00, 8'h00, 8'h01, 8'hb1};
    flush_stream();
    // widest f_code with user data on: user data, then a marker on the last byte
    apply_config(3'd7, 1'b0, 1'b1, 1'b1);
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'hb2, 8'h00, 8'h00, 8'h02, 8'h55};
    flush_stream();

    random_phase(3'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    random_phase(3'd7, 1'b0, 1'b1, 1'b0, 1'b1);
    random_phase(3'd3, 1'b1, 1'b1, 1'b1, 1'b0);
    random_phase(3'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    random_phase(3'd5, 1'b0, 1'b0, 1'b0, 1'b0);
    random_phase(3'd7, 1'b1, 1'b0, 1'b0, 1'b0);
    random_phase(3'd2, 1'b0, 1'b1, 1'b0, 1'b0);

    wait_drained();
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bascs_pkg.sv
rtl/core/byte_aligned_start_code_search_top.sv
tb/sv/start_code_checker.sv
tb/sv/tb_top.sv
